/* src/fnv_pkg.sv */
// Shared types, constants and the FNV-1a fold function for the record hasher.
package fnv_pkg;

    localparam int HASH_W = 64;
    localparam int NUM_W  = 32;
    localparam int DIGITS = 10;
    localparam int BCD_W  = 4 * DIGITS;
    localparam int CNT_W  = $clog2(NUM_W);

    localparam logic [HASH_W-1:0] STD_BASIS = 64'hCBF29CE484222325;

    localparam logic [7:0] CHAR_SEP   = 8'hFF;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [3:0] CHAR_DIGIT_HI = 4'h3;

    localparam logic [CNT_W-1:0] CONV_LAST  = CNT_W'(NUM_W - 1);
    localparam logic [CNT_W-1:0] DIGIT_LAST = CNT_W'(DIGITS - 1);

    typedef enum logic [1:0] {
        REQ_TEXT      = 2'd0,
        REQ_FIELD_END = 2'd1,
        REQ_FINISH    = 2'd2
    } fnv_req_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SIGN,
        S_CONV,
        S_DIG,
        S_COLON,
        S_SEP
    } fnv_state_t;

    typedef enum logic [2:0] {
        SRC_DATA,
        SRC_SEP,
        SRC_COLON,
        SRC_MINUS,
        SRC_DIGIT
    } fnv_src_t;

    typedef struct packed {
        logic     fold_en;
        fnv_src_t fold_src;
        logic     load_in;
        logic     conv_load_prio;
        logic     conv_step;
        logic     bcd_shift;
        logic     out_load;
        logic     reload;
    } fnv_cmd_t;

    typedef struct packed {
        logic       neg;
        logic [3:0] digit;
    } fnv_status_t;

    // h = (h ^ b) * 0x100000001B3 mod 2^64; the prime is 2^40 + 0x1B3
    function automatic logic [HASH_W-1:0] fnv_fold(input logic [HASH_W-1:0] h,
                                                   input logic [7:0] b);
        logic [HASH_W-1:0] x;
        x = h ^ {{(HASH_W-8){1'b0}}, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

/* src/fnv_apb_regs.sv */
// APB register file holding the offset basis.
module fnv_apb_regs (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [3:0]                paddr,
    input  logic [63:0]               pwdata,
    output logic [63:0]               prdata,
    output logic                      pready,
    output logic [fnv_pkg::HASH_W-1:0] basis
);
    import fnv_pkg::*;

    logic [HASH_W-1:0] basis_reg;
    logic [HASH_W-1:0] basis_next;
    logic              hit_basis;

    // register index is paddr[3]; basis is index 0
    assign hit_basis = (paddr[3] == 1'b0);

    always_comb
    begin
        basis_next = basis_reg;
        if (psel && penable && pwrite && hit_basis)
        begin
            basis_next = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            basis_reg <= STD_BASIS;
        end
        else
        begin
            basis_reg <= basis_next;
        end
    end

    assign prdata = hit_basis ? basis_reg : 64'd0;
    assign pready = 1'b1;
    assign basis  = basis_reg;

endmodule

/* src/fnv_datapath.sv */
// Datapath: running hash, fold unit, number capture and binary-to-BCD converter.
module fnv_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  fnv_pkg::fnv_cmd_t           cmd,
    input  logic [7:0]                  data_byte,
    input  logic [fnv_pkg::NUM_W-1:0]   position,
    input  logic [fnv_pkg::NUM_W-1:0]   priority_req,
    input  logic [fnv_pkg::HASH_W-1:0]  basis,
    output fnv_pkg::fnv_status_t        status,
    output logic [fnv_pkg::HASH_W-1:0]  hash_value
);
    import fnv_pkg::*;

    logic [HASH_W-1:0] hash_reg, hash_next;
    logic [HASH_W-1:0] out_reg, out_next;
    logic [NUM_W-1:0]  prio_reg, prio_next;
    logic [NUM_W-1:0]  bin_reg, bin_next;
    logic [BCD_W-1:0]  bcd_reg, bcd_next;
    logic              neg_reg, neg_next;

    logic [7:0]        fold_byte;
    logic [HASH_W-1:0] fold_res;
    logic [BCD_W-1:0]  bcd_adj;

    always_comb
    begin
        case (cmd.fold_src)
            SRC_DATA:  fold_byte = data_byte;
            SRC_SEP:   fold_byte = CHAR_SEP;
            SRC_COLON: fold_byte = CHAR_COLON;
            SRC_MINUS: fold_byte = CHAR_MINUS;
            SRC_DIGIT: fold_byte = {CHAR_DIGIT_HI, bcd_reg[BCD_W-1 -: 4]};
            default:   fold_byte = CHAR_SEP;
        endcase
    end

    assign fold_res = fnv_fold(hash_reg, fold_byte);

    // double dabble: add 3 to any digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb
    begin
        hash_next = hash_reg;
        out_next  = out_reg;
        prio_next = prio_reg;
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        neg_next  = neg_reg;

        if (cmd.fold_en)
        begin
            hash_next = fold_res;
        end
        if (cmd.out_load)
        begin
            out_next = fold_res;
        end
        if (cmd.reload)
        begin
            hash_next = basis;
        end

        if (cmd.load_in)
        begin
            prio_next = priority_req;
            neg_next  = position[NUM_W-1];
            bin_next  = position[NUM_W-1] ? (~position + 1'b1) : position;
            bcd_next  = '0;
        end
        else if (cmd.conv_load_prio)
        begin
            neg_next = prio_reg[NUM_W-1];
            bin_next = prio_reg[NUM_W-1] ? (~prio_reg + 1'b1) : prio_reg;
            bcd_next = '0;
        end
        else if (cmd.conv_step)
        begin
            {bcd_next, bin_next} = {bcd_adj[BCD_W-2:0], bin_reg, 1'b0};
        end
        else if (cmd.bcd_shift)
        begin
            bcd_next = {bcd_reg[BCD_W-5:0], 4'h0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= STD_BASIS;
        end
        else
        begin
            hash_reg <= hash_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        prio_reg <= prio_next;
        bin_reg  <= bin_next;
        bcd_reg  <= bcd_next;
        neg_reg  <= neg_next;
    end

    assign status.neg   = neg_reg;
    assign status.digit = bcd_reg[BCD_W-1 -: 4];
    assign hash_value   = out_reg;

endmodule

/* src/fnv_ctrl.sv */
// Controller: sequences text folds and the decimal formatting of a finish.
module fnv_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [1:0]           req_type,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  fnv_pkg::fnv_status_t status,
    output fnv_pkg::fnv_cmd_t    cmd
);
    import fnv_pkg::*;

    fnv_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             second_reg, second_next;
    logic             started_reg, started_next;
    logic             valid_reg, valid_next;
    logic             out_free;
    logic             digit_fold;

    assign out_free   = !valid_reg || out_ready;
    // leading zeros are skipped, but the last digit always goes out
    assign digit_fold = (status.digit != 4'd0) || started_reg || (cnt_reg == DIGIT_LAST);

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        second_next  = second_reg;
        started_next = started_reg;
        valid_next   = valid_reg && !out_ready;
        in_ready     = 1'b0;
        cmd          = '0;
        cmd.fold_src = SRC_DATA;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (fnv_req_t'(req_type))
                        REQ_TEXT:
                        begin
                            cmd.fold_en  = 1'b1;
                            cmd.fold_src = SRC_DATA;
                        end
                        REQ_FIELD_END:
                        begin
                            cmd.fold_en  = 1'b1;
                            cmd.fold_src = SRC_SEP;
                        end
                        REQ_FINISH:
                        begin
                            cmd.load_in = 1'b1;
                            second_next = 1'b0;
                            state_next  = S_SIGN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SIGN:
            begin
                cmd.fold_en  = status.neg;
                cmd.fold_src = SRC_MINUS;
                cnt_next     = '0;
                started_next = 1'b0;
                state_next   = S_CONV;
            end
            S_CONV:
            begin
                cmd.conv_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == CONV_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_DIG;
                end
            end
            S_DIG:
            begin
                cmd.fold_en   = digit_fold;
                cmd.fold_src  = SRC_DIGIT;
                cmd.bcd_shift = 1'b1;
                started_next  = started_reg || digit_fold;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == DIGIT_LAST)
                begin
                    state_next = second_reg ? S_SEP : S_COLON;
                end
            end
            S_COLON:
            begin
                cmd.fold_en        = 1'b1;
                cmd.fold_src       = SRC_COLON;
                cmd.conv_load_prio = 1'b1;
                second_next        = 1'b1;
                state_next         = S_SIGN;
            end
            S_SEP:
            begin
                cmd.fold_src = SRC_SEP;
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.reload   = 1'b1;
                    valid_next   = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            second_reg  <= 1'b0;
            started_reg <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            second_reg  <= second_next;
            started_reg <= started_next;
            valid_reg   <= valid_next;
        end
    end

    assign out_valid = valid_reg;

`ifndef SYNTHESIS
    a_dig_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIG |-> cnt_reg <= DIGIT_LAST)
        else $error("digit counter past last digit");

    a_bcd_digit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIG |-> status.digit <= 4'd9)
        else $error("converter produced a non-decimal digit");

    a_finish_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && in_valid && req_type == REQ_FINISH) |=> state_reg == S_SIGN)
        else $error("finish beat did not start formatting");

    a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEP && out_free) |=> (valid_reg && state_reg == S_IDLE))
        else $error("finished hash not presented");
`endif

endmodule

/* src/fnv1a_record_hasher.sv */
// Top level of the FNV-1a 64-bit record hasher.
//
// Input stream (s_*): one beat per request. s_tuser carries req_type: text
// byte, end of field (folds 0xFF) or finish. Text bytes and field ends stream
// at one beat per cycle while no finish is being formatted. A finish formats
// position and priority_req as signed decimal, folds "pos:prio" and a final
// 0xFF, and then presents the hash on the output stream. Each number takes a
// sign step, the bit-serial binary-to-BCD conversion and the digit folds;
// s_tready is low meanwhile. Output stream (m_*): a registered result. Text
// beats are still taken while a hash waits; if the receiver stalls, a
// following finish waits in its last step until the held hash is taken.
// APB: register 0 (byte address 0) is the 64-bit offset basis loaded into the
// running hash after each finished record. Write only while idle.
// Reset: running hash and basis take the published FNV-1a basis, no result
// is pending, and the input is ready right away.
module fnv1a_record_hasher (
    input  logic        clk,
    input  logic        rst_n,
    // s_tdata: data_byte[7:0], position[39:8], priority_req[71:40]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,
    // s_tuser: req_type[1:0]
    input  logic [1:0]  s_tuser,
    // m_tdata: hash_value[63:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import fnv_pkg::*;

    fnv_cmd_t          cmd;
    fnv_status_t       status;
    logic [HASH_W-1:0] basis;

    fnv_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .basis   (basis)
    );

    fnv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .req_type  (s_tuser),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    fnv_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .data_byte    (s_tdata[7:0]),
        .position     (s_tdata[39:8]),
        .priority_req (s_tdata[71:40]),
        .basis        (basis),
        .status       (status),
        .hash_value   (m_tdata)
    );

endmodule

/* test/tb_top.sv */
// Self-checking testbench for fnv1a_record_hasher: streamed records against a hash predictor.
`timescale 1ns / 1ps

module tb_top;
    import fnv_pkg::*;

    localparam logic [1:0]  REQ_UNUSED = 2'd3;        // code the block ignores
    localparam logic [3:0]  ADDR_BASIS = 4'd0;        // offset basis register
    localparam logic [63:0] FILE_BASIS = 64'd1469598103934665603;
    localparam logic [63:0] FNV_PRIME  = 64'd1099511628211;
    localparam int DRAIN_CYCLES = 100;                // extra wait once no hash is due
    localparam int IDLE_LIMIT   = 2000;               // cycles with no beat on either side
    localparam int RANDOM_ITEMS = 1500;

    // Predicts the hash of each finished record and holds the ones still due.
    class record_hash_tracker;
        logic [63:0] basis;
        logic [63:0] running;
        logic [63:0] hashes_due[$];
        int unsigned faults;

        function new();
            basis   = STD_BASIS;
            running = STD_BASIS;
            faults  = 0;
        endfunction

        function logic [63:0] mix(logic [63:0] h, logic [7:0] c);
            return (h ^ {56'd0, c}) * FNV_PRIME;
        endfunction

        // One accepted request beat.
        function void take_request(logic [1:0] req, logic [7:0] b, int pos, int prio);
            string digits;
            logic [63:0] h;
            case (req)
                REQ_TEXT:      running = mix(running, b);
                REQ_FIELD_END: running = mix(running, CHAR_SEP);
                REQ_FINISH:
                begin
                    digits = $sformatf("%0d:%0d", pos, prio);
                    h = running;
                    for (int i = 0; i < digits.len(); i++)
                        h = mix(h, digits[i]);
                    hashes_due.push_back(mix(h, CHAR_SEP));
                    running = basis;
                end
                default: ;  // unused code: no effect
            endcase
        endfunction

        // One accepted hash beat.
        function void match_hash(logic [63:0] got);
            logic [63:0] want;
            if (hashes_due.size() == 0)
            begin
                $error("hash_value: none expected, got %h", got);
                faults++;
                return;
            end
            want = hashes_due.pop_front();
            if (got !== want)
            begin
                $error("hash_value: expected %h, got %h", want, got);
                faults++;
            end
        endfunction

        function int pending();
            return hashes_due.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;    // data_byte[7:0], position[39:8], priority_req[71:40]
    logic [1:0]  s_tuser;    // req_type[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;    // hash_value[63:0]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    fnv1a_record_hasher uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    record_hash_tracker tracker = new();

    int unsigned beats_sent  = 0;   // requests that do something (unused code excluded)
    int unsigned burst_left  = 0;
    int unsigned idle_cycles = 0;
    int unsigned stall_mode  = 0;
    int unsigned stall_tick  = 0;

    always #4 clk = ~clk;

    // Receiver backpressure: switches between always ready, coin flips and
    // long periodic stalls so a held hash meets a following finish.
    always @(negedge clk)
    begin
        if (stall_tick == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_tick = $urandom_range(50, 400);
        end
        stall_tick--;
        case (stall_mode)
            0:       m_tready = 1'b1;
            1:       m_tready = 1'($urandom_range(0, 1));
            default: m_tready = (stall_tick % 37) < 12;
        endcase
    end

    // Output monitor, sampled at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.match_hash(m_tdata);
    end

    // Watchdog on cycles with no beat on either stream.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Drive one request beat; the sender runs in random bursts with gaps.
    task automatic send_beat(logic [1:0] req, logic [7:0] b, logic [31:0] pos,
                             logic [31:0] prio);
        @(negedge clk);
        if (burst_left == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 12);
        end
        s_tvalid = 1'b1;
        s_tuser  = req;
        s_tdata  = {prio, pos, b};
        do @(posedge clk); while (!s_tready);
        tracker.take_request(req, b, pos, prio);
        if (req != REQ_UNUSED)
            beats_sent++;
        burst_left--;
    endtask

    // Text beat: random numbers ride along unused.
    task automatic send_text(logic [7:0] b);
        send_beat(REQ_TEXT, b, $urandom, $urandom);
    endtask

    task automatic send_finish(logic [31:0] pos, logic [31:0] prio);
        send_beat(REQ_FINISH, 8'($urandom), pos, prio);
    endtask

    // Short numbers, full-range random ones, the extremes and decade edges.
    function automatic logic [31:0] pick_number();
        int unsigned p;
        case ($urandom_range(0, 6))
            0: return $urandom_range(0, 99);
            1: return -$urandom_range(1, 99);
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4:
            begin
                p = 1;
                repeat ($urandom_range(0, 9)) p = p * 10;
                p = p - $urandom_range(0, 1);
                return $urandom_range(0, 1) ? p : -p;
            end
            default: return $urandom;
        endcase
    endfunction

    // A record: text and field-end beats with a little unused-code noise,
    // usually closed by a finish; some are left open into the next record.
    task automatic send_record();
        int unsigned len;
        int unsigned pick;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 10);
        repeat (len)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
                send_text(8'($urandom_range(0, 255)));
            else if (pick < 95)
                send_beat(REQ_FIELD_END, 8'($urandom), $urandom, $urandom);
            else
                send_beat(REQ_UNUSED, 8'($urandom), $urandom, $urandom);
        end
        if ($urandom_range(0, 9) != 0)
            send_finish(pick_number(), pick_number());
    endtask

    // Let the block drain, then write the basis and read it back.
    task automatic set_basis(logic [63:0] value);
        @(negedge clk);
        s_tvalid   = 1'b0;
        burst_left = 0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        @(negedge clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        paddr   = ADDR_BASIS;
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        tracker.basis = value;

        @(negedge clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== value)
        begin
            $error("offset_basis: expected %h, got %h", value, prdata);
            tracker.faults++;
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    initial
    begin
        logic [63:0] phase_basis[5];

        clk      = 1'b0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = REQ_TEXT;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = ADDR_BASIS;
        pwdata   = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // Directed part, on the reset basis.
        send_text(8'h00);
        send_text(8'hFF);
        send_text(8'h41);
        send_beat(REQ_FIELD_END, 8'h00, 32'd0, 32'd0);
        send_beat(REQ_FIELD_END, 8'h00, 32'd0, 32'd0);    // empty field
        send_beat(REQ_UNUSED, 8'hA5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_finish(32'h8000_0000, 32'h7FFF_FFFF);        // most negative in full
        send_finish(32'd0, 32'd0);                        // empty record
        send_text(8'h7F);
        send_text(8'h80);
        send_finish(32'h7FFF_FFFF, 32'h8000_0000);
        send_finish(-32'sd1, -32'sd12);
        send_beat(REQ_FIELD_END, 8'h00, 32'd0, 32'd0);    // missing field
        send_finish(32'd9, 32'd10);
        send_text(8'h55);
        send_text(8'hAA);
        // Record left open: the new basis must not touch the running hash.
        set_basis(FILE_BASIS);
        send_finish(32'd1000000000, -32'sd999999999);

        // Random part in phases, each on its own basis.
        phase_basis[0] = FILE_BASIS;
        phase_basis[1] = 64'd0;
        phase_basis[2] = '1;
        phase_basis[3] = {$urandom, $urandom};
        phase_basis[4] = STD_BASIS;
        for (int ph = 0; ph < 5; ph++)
        begin
            if (ph != 0)
                set_basis(phase_basis[ph]);
            while (beats_sent < (ph + 1) * RANDOM_ITEMS / 5 + 18)
                send_record();
        end
        send_finish(pick_number(), pick_number());

        @(negedge clk);
        s_tvalid = 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (tracker.faults == 0 && tracker.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
